// File: design/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared types and constants of the symbol dictionary indexer: table size,
// field widths, function codes and the transaction record moved along the
// row of compare cells.
// ----------------------------------------------------------------------------
package sdi_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int SYM_W       = 16;
  localparam int INDEX_W     = 8;
  localparam int TOTAL_W     = 9;

  typedef enum logic {
    FUNC_LEARN = 1'b0,
    FUNC_MAP   = 1'b1
  } func_t;

  typedef struct packed {
    logic               valid;
    func_t              func;
    logic [SYM_W-1:0]   symbol;
    logic               found;
    logic               stored;
    logic               bound;
    logic [INDEX_W-1:0] index;
    logic [TOTAL_W-1:0] total;
  } item_t;

endpackage

// File: design/sdi_cell.sv
// ----------------------------------------------------------------------------
// sdi_cell
// One table entry with its compare logic. Checks the passing transaction
// against the stored symbol, appends it at the fill boundary and hands the
// updated transaction to the next cell.
// ----------------------------------------------------------------------------
module sdi_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [sdi_pkg::IDX_W-1:0]  cell_idx,
  input  logic [sdi_pkg::CNT_W-1:0]  cnt,
  input  sdi_pkg::item_t             item_in,
  output sdi_pkg::item_t             item_out,
  output logic                       ins
);

  logic [sdi_pkg::SYM_W-1:0] entry_r;
  sdi_pkg::item_t            item_r;
  sdi_pkg::item_t            item_nxt;
  logic                      occupied;
  logic                      at_bound;
  logic                      hit;
  logic                      put;

  assign occupied = sdi_pkg::CNT_W'(cell_idx) < cnt;
  assign at_bound = item_in.valid && !item_in.bound &&
                    (sdi_pkg::CNT_W'(cell_idx) == cnt);
  assign hit      = item_in.valid && occupied && !item_in.found &&
                    (entry_r == item_in.symbol);
  assign put      = at_bound && !item_in.found && (item_in.func == sdi_pkg::FUNC_LEARN) &&
                    (item_in.symbol != '0);
  assign ins      = adv && put;

  always_comb begin
    item_nxt        = item_in;
    item_nxt.found  = item_in.found | hit;
    item_nxt.stored = item_in.stored | put;
    item_nxt.bound  = item_in.bound | at_bound;
    if (hit || put) begin
      item_nxt.index = sdi_pkg::INDEX_W'(cell_idx);
    end
    if (at_bound) begin
      item_nxt.total = sdi_pkg::TOTAL_W'(cnt + sdi_pkg::CNT_W'(put));
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      entry_r <= item_in.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;

endmodule

// File: design/symbol_dictionary_indexer.sv
// ----------------------------------------------------------------------------
// symbol_dictionary_indexer
// Builds a vocabulary of distinct nonzero 16-bit symbols in order of first
// appearance and maps symbols to their vocabulary index.
//
// Input channel (in_valid/in_stall): in_func selects learn (append if new)
// or map (look up only); in_symbol is the symbol. Result channel
// (out_valid/out_stall): index, found, stored, table_full, entry_total.
// Every input transaction gives exactly one result, in order.
//
// Transactions walk a row of TABLE_DEPTH compare cells, one cell per cycle
// while the row moves, each cell holding one entry, and then the result
// register before out_valid; a new transaction is taken every cycle while
// in_stall is low.
// A transaction appends itself at the cell where the fill boundary sits.
//
// Reset (rst_n low, synchronous) empties the row and the result register;
// no clearing pass is needed, entries are judged by the fill count.
// While a result waits under out_stall the whole row holds and in_stall
// is raised; the row moves again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module symbol_dictionary_indexer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [sdi_pkg::SYM_W-1:0]     in_symbol,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdi_pkg::INDEX_W-1:0]   out_index,
  output logic                          out_found,
  output logic                          out_stored,
  output logic                          out_table_full,
  output logic [sdi_pkg::TOTAL_W-1:0]   out_entry_total
);

  sdi_pkg::item_t                     in_item;
  sdi_pkg::item_t                     chain [sdi_pkg::TABLE_DEPTH];
  sdi_pkg::item_t                     tail;
  logic [sdi_pkg::TABLE_DEPTH-1:0]    ins_vec;
  logic [sdi_pkg::CNT_W-1:0]          count_r;
  logic [sdi_pkg::CNT_W-1:0]          count_nxt;
  logic                               adv;

  logic                               out_valid_r;
  logic [sdi_pkg::INDEX_W-1:0]        out_index_r;
  logic                               out_found_r;
  logic                               out_stored_r;
  logic                               out_full_r;
  logic [sdi_pkg::TOTAL_W-1:0]        out_total_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    in_item        = '0;
    in_item.valid  = in_valid;
    in_item.func   = sdi_pkg::func_t'(in_func);
    in_item.symbol = in_symbol;
  end

  for (genvar k = 0; k < sdi_pkg::TABLE_DEPTH; k++) begin : g_cell
    sdi_pkg::item_t cell_in;
    if (k == 0) begin : g_head
      assign cell_in = in_item;
    end else begin : g_body
      assign cell_in = chain[k-1];
    end
    sdi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (sdi_pkg::IDX_W'(k)),
      .cnt      (count_r),
      .item_in  (cell_in),
      .item_out (chain[k]),
      .ins      (ins_vec[k])
    );
  end

  assign count_nxt = count_r + sdi_pkg::CNT_W'(|ins_vec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign tail = chain[sdi_pkg::TABLE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index_r  <= tail.index;
      out_found_r  <= tail.found;
      out_stored_r <= tail.stored;
      out_full_r   <= !tail.bound && !tail.found && (tail.func == sdi_pkg::FUNC_LEARN) &&
                      (tail.symbol != '0);
      out_total_r  <= tail.bound ? tail.total : sdi_pkg::TOTAL_W'(sdi_pkg::TABLE_DEPTH);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_index       = out_index_r;
  assign out_found       = out_found_r;
  assign out_stored      = out_stored_r;
  assign out_table_full  = out_full_r;
  assign out_entry_total = out_total_r;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sdi_pkg::CNT_W'(sdi_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_single_insert : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ins_vec))
    else $error("more than one cell appended in a cycle");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    (|ins_vec) |=> (count_r == $past(count_r) + 1'b1))
    else $error("entry count did not follow an append");

  a_insert_on_adv : assert property (@(posedge clk) disable iff (!rst_n)
    (|ins_vec) |-> adv)
    else $error("append while the row is held");

  a_result_flags : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones({out_found_r, out_stored_r, out_full_r}) <= 1))
    else $error("conflicting result flags");
`endif

endmodule

// File: test/vocab_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// vocab_scoreboard_pkg
// Scoreboard for the symbol dictionary indexer. It keeps its own vocabulary,
// works out the result of every accepted input transaction, queues it, and
// compares each returned result against the oldest queued one.
// ----------------------------------------------------------------------------
package vocab_scoreboard_pkg;

  import sdi_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               found;
    logic               stored;
    logic               table_full;
    logic [TOTAL_W-1:0] entry_total;
  } vocab_result_t;

  class vocab_scoreboard;
    logic [SYM_W-1:0] entries [TABLE_DEPTH];
    int               fill;
    vocab_result_t    pending [$];
    int               failures;
    int               checked;
    int               n_stored;
    int               n_hit;
    int               n_full;
    int               n_miss;
    int               n_zero;

    function new();
      fill     = 0;
      failures = 0;
      checked  = 0;
      n_stored = 0;
      n_hit    = 0;
      n_full   = 0;
      n_miss   = 0;
      n_zero   = 0;
    endfunction

    function void note_symbol(func_t f, logic [SYM_W-1:0] s);
      vocab_result_t r;
      int            pos;
      r   = '0;
      pos = -1;
      for (int k = 0; k < fill; k++)
        if (pos < 0 && entries[k] == s) pos = k;
      if (pos >= 0) begin
        r.found = 1'b1;
        r.index = INDEX_W'(pos);
        n_hit++;
      end else if (f == FUNC_LEARN && s != '0) begin
        if (fill < TABLE_DEPTH) begin
          entries[fill] = s;
          r.index  = INDEX_W'(fill);
          r.stored = 1'b1;
          fill++;
          n_stored++;
        end else begin
          r.table_full = 1'b1;
          n_full++;
        end
      end else if (f == FUNC_LEARN) begin
        n_zero++;
      end else begin
        n_miss++;
      end
      r.entry_total = TOTAL_W'(fill);
      pending.push_back(r);
    endfunction

    function void check_result(vocab_result_t got);
      vocab_result_t exp;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t unexpected result: index %0d found %0b stored %0b full %0b total %0d",
                   $time, got.index, got.found, got.stored, got.table_full,
                   got.entry_total);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.index !== exp.index || got.found !== exp.found ||
          got.stored !== exp.stored || got.table_full !== exp.table_full ||
          got.entry_total !== exp.entry_total) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t mismatch: exp index %0d found %0b stored %0b full %0b total %0d",
                   $time, exp.index, exp.found, exp.stored, exp.table_full,
                   exp.entry_total);
          $display("  got index %0d found %0b stored %0b full %0b total %0d",
                   got.index, got.found, got.stored, got.table_full,
                   got.entry_total);
        end
      end
    endfunction
  endclass

endpackage

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the symbol dictionary indexer with a directed opening (empty table,
// zero symbols, extremes, hits in both functions) and then a long random
// stream that fills the vocabulary and runs on past full, with random gaps
// and result stalls. Every result is checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import sdi_pkg::*;
  import vocab_scoreboard_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1280;
  localparam int TAIL_CYCLES    = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_func;
  logic [SYM_W-1:0]   in_symbol;
  logic               out_valid;
  logic               out_stall;
  logic [INDEX_W-1:0] out_index;
  logic               out_found;
  logic               out_stored;
  logic               out_table_full;
  logic [TOTAL_W-1:0] out_entry_total;

  vocab_scoreboard sb;
  bit              in_burst;
  bit              out_burst;
  int              quiet;

  symbol_dictionary_indexer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_symbol       (in_symbol),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_index       (out_index),
    .out_found       (out_found),
    .out_stored      (out_stored),
    .out_table_full  (out_table_full),
    .out_entry_total (out_entry_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_symbol(input func_t f, input logic [SYM_W-1:0] s);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_symbol <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_symbol(f, s);
  endtask

  task automatic drain_vocab;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // result side
  initial begin
    vocab_result_t got;
    int            hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.index       = out_index;
      got.found       = out_found;
      got.stored      = out_stored;
      got.table_full  = out_table_full;
      got.entry_total = out_entry_total;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int               r;
    func_t            f;
    logic [SYM_W-1:0] s;
    sb = new();
    quiet = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_func   <= FUNC_LEARN;
    in_symbol <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, zero symbols, extremes, hits in both functions
    send_symbol(FUNC_MAP,   16'h0000);
    send_symbol(FUNC_LEARN, 16'h0000);
    send_symbol(FUNC_MAP,   16'h1234);
    send_symbol(FUNC_LEARN, 16'hFFFF);
    send_symbol(FUNC_LEARN, 16'h0001);
    send_symbol(FUNC_LEARN, 16'hFFFF);
    send_symbol(FUNC_MAP,   16'hFFFF);
    send_symbol(FUNC_MAP,   16'h0001);
    send_symbol(FUNC_LEARN, 16'h8000);
    send_symbol(FUNC_MAP,   16'h7FFF);
    send_symbol(FUNC_LEARN, 16'h0000);
    send_symbol(FUNC_MAP,   16'h0000);
    send_symbol(FUNC_LEARN, 16'hAAAA);
    send_symbol(FUNC_LEARN, 16'h5555);
    send_symbol(FUNC_MAP,   16'h5555);
    send_symbol(FUNC_LEARN, 16'h0001);
    send_symbol(FUNC_MAP,   16'h8000);
    send_symbol(FUNC_LEARN, 16'h7FFF);
    send_symbol(FUNC_MAP,   16'h7FFF);
    send_symbol(FUNC_MAP,   16'hAAAA);
    drain_vocab();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
      if (i == RANDOM_ITEMS / 2) drain_vocab();
      r = $urandom_range(0, 99);
      if (r < 40) begin
        f = FUNC_LEARN;
        s = SYM_W'($urandom_range(1, 65535));
      end else if (r < 80 && sb.fill > 0) begin
        f = (r < 60) ? FUNC_LEARN : FUNC_MAP;
        s = sb.entries[$urandom_range(0, sb.fill - 1)];
      end else if (r < 92) begin
        f = FUNC_MAP;
        s = SYM_W'($urandom_range(0, 65535));
      end else begin
        f = (r < 96) ? FUNC_LEARN : FUNC_MAP;
        s = '0;
      end
      send_symbol(f, s);
    end

    drain_vocab();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.failures += sb.pending.size();
      $display("%0d results never returned", sb.pending.size());
    end

    $display("covered %0d transactions: %0d appended, %0d hits, %0d rejected on full table",
             sb.checked, sb.n_stored, sb.n_hit, sb.n_full);
    $display("  %0d map misses, %0d zero learns, vocabulary ended at %0d entries",
             sb.n_miss, sb.n_zero, sb.fill);
    if (sb.failures == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// File: symbol_dictionary_indexer.f
design/sdi_pkg.sv
design/sdi_cell.sv
design/symbol_dictionary_indexer.sv
test/vocab_scoreboard_pkg.sv
test/tb_top.sv
